[hw/rtl/far_pkg.sv]
// Package with shared constants and types for the fraction arithmetic block.
package far_pkg;

    localparam int OPERAND_BITS_DEF = 16;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } far_unit_ctl_t;

endpackage

[hw/rtl/far_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
module far_divider #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    import far_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("divider done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("divider done without work");
endmodule

[hw/rtl/fraction_arith_reduce.sv]
// Top level of the fraction arithmetic and reduction block.
// Usage: an item on the input channel carries op and four operands a, b, c, d.
// The block forms m and n by cross multiplication, using one shared multiplier
// of operand width, then for add and subtract combines the two products by their
// signs. Unless the item is in error or m or n is zero, it reduces m/n by Euclid's
// algorithm on one shared restoring divider that produces one quotient bit a cycle,
// then divides m and n by the divisor and finally m by n.
// One item is processed at a time; ready is low while an item is in work.
// The result sits in an output register until taken; while the receiver
// stalls, no new item is accepted. Reset clears the sequencer and drops any
// item in flight; no result is valid after reset.
module fraction_arith_reduce #(
    parameter int OPERAND_BITS = far_pkg::OPERAND_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] num_a,
    input  logic [15:0] den_b,
    input  logic [15:0] num_c,
    input  logic [15:0] den_d,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        error,
    output logic        negative,
    output logic [31:0] whole_part,
    output logic [29:0] remainder_part,
    output logic [30:0] denominator
);
    import far_pkg::*;

    localparam int OB = OPERAND_BITS;
    localparam int PW = 2 * OB;
    localparam int DW = PW + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_MUL3 = 4'd4;
    localparam logic [3:0] S_SUM = 4'd5;
    localparam logic [3:0] S_GCD = 4'd6;
    localparam logic [3:0] S_DIVM = 4'd7;
    localparam logic [3:0] S_DIVN = 4'd8;
    localparam logic [3:0] S_FIN = 4'd9;
    localparam logic [3:0] S_OUT = 4'd10;
    localparam logic [3:0] S_WAIT = 4'd11;

    logic [3:0]    state_reg;
    logic [1:0]    op_reg;
    logic [OB-1:0] am_reg, bm_reg, cm_reg, dm_reg;
    logic          an_reg, bn_reg, cn_reg, dn_reg;
    logic [PW-1:0] p0_reg, p1_reg, nmag_reg;
    logic [DW-1:0] mmag_reg, gx_reg, gy_reg, pn_reg;
    logic          mneg_reg;
    logic          err_reg, neg_reg;
    logic [31:0]   whole_reg;
    logic [29:0]   rem_reg;
    logic [30:0]   den_reg;
    logic          ov_reg;

    logic [OB-1:0] mul_x, mul_y;
    logic [PW-1:0] mul_p;
    logic          dv_start;
    logic [DW-1:0] dv_a, dv_b, dv_q, dv_r;
    logic          dv_busy;
    logic          dv_done;

    function automatic logic [OB:0] load_op(input logic [15:0] raw);
        logic [OB-1:0] v;
        logic [OB-1:0] mag;
        v = OB'(raw);
        mag = v[OB-1] ? (~v + 1'b1) : v;
        return {v[OB-1], mag};
    endfunction

    logic [OB:0] la, lb, lc, ld;
    assign la = load_op(num_a);
    assign lb = load_op(den_b);
    assign lc = load_op(num_c);
    assign ld = load_op(den_d);

    // A negative operand with zero magnitude is given the magnitude of the most negative value.
    function automatic logic [OB-1:0] fix_mag(input logic [OB:0] l);
        return (l[OB] && l[OB-1:0] == '0) ? {1'b1, {(OB-1){1'b0}}} : l[OB-1:0];
    endfunction

    far_divider #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
        .divisor(dv_b), .busy(dv_busy), .done(dv_done),
        .quotient(dv_q), .remainder(dv_r)
    );

    always_comb
    begin
        mul_x = am_reg;
        mul_y = dm_reg;
        case (state_reg)
            S_MUL0:
            begin
                mul_x = am_reg;
                mul_y = (op_reg == OP_MUL) ? cm_reg : dm_reg;
            end
            S_MUL1:
            begin
                mul_x = bm_reg;
                mul_y = cm_reg;
            end
            S_MUL2:
            begin
                mul_x = bm_reg;
                mul_y = (op_reg == OP_DIV) ? cm_reg : dm_reg;
            end
            default:
            begin
                mul_x = am_reg;
                mul_y = dm_reg;
            end
        endcase
    end
    assign mul_p = PW'(mul_x) * PW'(mul_y);

    logic          s0, s1, sn;
    logic [DW-1:0] sum_mag;
    logic          sum_neg;
    always_comb
    begin
        s0 = (op_reg == OP_MUL) ? (an_reg ^ cn_reg) : (an_reg ^ dn_reg);
        s1 = (bn_reg ^ cn_reg) ^ (op_reg == OP_SUB);
        sn = (op_reg == OP_DIV) ? (bn_reg ^ cn_reg) : (bn_reg ^ dn_reg);
        if (op_reg == OP_MUL || op_reg == OP_DIV || p1_reg == '0)
        begin
            sum_mag = DW'(p0_reg);
            sum_neg = s0;
        end
        else if (p0_reg == '0)
        begin
            sum_mag = DW'(p1_reg);
            sum_neg = s1;
        end
        else if (s0 == s1)
        begin
            sum_mag = DW'(p0_reg) + DW'(p1_reg);
            sum_neg = s0;
        end
        else if (p0_reg >= p1_reg)
        begin
            sum_mag = DW'(p0_reg - p1_reg);
            sum_neg = s0;
        end
        else
        begin
            sum_mag = DW'(p1_reg - p0_reg);
            sum_neg = s1;
        end
        sn = sn & 1'b1;
    end

    always_comb
    begin
        dv_start = 1'b0;
        dv_a = gx_reg;
        dv_b = gy_reg;
        case (state_reg)
            S_GCD:
            begin
                dv_a = gx_reg;
                dv_b = gy_reg;
                dv_start = !dv_busy && !dv_done && gy_reg != '0;
            end
            S_DIVM:
            begin
                dv_a = mmag_reg;
                dv_b = gx_reg;
                dv_start = !dv_busy && !dv_done;
            end
            S_DIVN:
            begin
                dv_a = DW'(nmag_reg);
                dv_b = gx_reg;
                dv_start = !dv_busy && !dv_done;
            end
            S_FIN:
            begin
                dv_a = pn_reg;
                dv_b = gy_reg;
                dv_start = !dv_busy && !dv_done;
            end
            default:
            begin
                dv_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_MUL0;
                    end
                end
                S_MUL0:
                begin
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    state_reg <= S_SUM;
                end
                S_MUL3:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (err_reg || sum_mag == '0 || nmag_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_GCD;
                    end
                end
                S_GCD:
                begin
                    if (gy_reg == '0 && !dv_busy)
                    begin
                        state_reg <= S_DIVM;
                    end
                end
                S_DIVM:
                begin
                    if (dv_done)
                    begin
                        state_reg <= S_DIVN;
                    end
                end
                S_DIVN:
                begin
                    if (dv_done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (dv_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    ov_reg <= 1'b1;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (out_ready)
                    begin
                        ov_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg <= op;
                an_reg <= la[OB];
                bn_reg <= lb[OB];
                cn_reg <= lc[OB];
                dn_reg <= ld[OB];
                am_reg <= fix_mag(la);
                bm_reg <= fix_mag(lb);
                cm_reg <= fix_mag(lc);
                dm_reg <= fix_mag(ld);
                err_reg <= (lb[OB:0] == '0) || (ld[OB:0] == '0)
                           || (op == OP_DIV && lc[OB:0] == '0);
                neg_reg <= 1'b0;
                whole_reg <= '0;
                rem_reg <= '0;
                den_reg <= 31'd1;
            end
            S_MUL0:
            begin
                p0_reg <= mul_p;
            end
            S_MUL1:
            begin
                p1_reg <= mul_p;
            end
            S_MUL2:
            begin
                nmag_reg <= mul_p;
            end
            S_SUM:
            begin
                mmag_reg <= sum_mag;
                mneg_reg <= sum_neg;
                gx_reg <= sum_mag;
                gy_reg <= DW'(nmag_reg);
            end
            S_GCD:
            begin
                if (dv_done)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= dv_r;
                end
            end
            S_DIVM:
            begin
                if (dv_done)
                begin
                    pn_reg <= dv_q;
                end
            end
            S_DIVN:
            begin
                if (dv_done)
                begin
                    gy_reg <= dv_q;
                    den_reg <= 31'(dv_q);
                    neg_reg <= mneg_reg ^ sn;
                end
            end
            S_FIN:
            begin
                if (dv_done)
                begin
                    whole_reg <= 32'(dv_q);
                    rem_reg <= 30'(dv_r);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign error = err_reg;
    assign negative = neg_reg;
    assign whole_part = whole_reg;
    assign remainder_part = rem_reg;
    assign denominator = den_reg;

    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input accepted while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (denominator == 31'd1 && !negative))
        else $error("error result malformed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !error) |-> (denominator != '0))
        else $error("zero denominator delivered");
endmodule

[bench/tb_fraction_arith_reduce.sv]
// Testbench for fraction_arith_reduce: random and directed fraction items checked by a scoreboard.
`timescale 1ns / 1ps

module tb_fraction_arith_reduce;
    import far_pkg::*;

    typedef struct {
        logic        error;
        logic        negative;
        logic [31:0] whole_part;
        logic [29:0] remainder_part;
        logic [30:0] denominator;
    } frac_result_t;

    class frac_scoreboard;
        frac_result_t pending[$];
        int           failures;

        function new();
            failures = 0;
        endfunction

        // Exact cross multiplication in 64-bit signed arithmetic, then reduction.
        function void note_item(logic [1:0] op_i, logic [15:0] a_i, logic [15:0] b_i,
                                logic [15:0] c_i, logic [15:0] d_i);
            frac_result_t r;
            longint a, b, c, d, m, n;
            longint unsigned um, un, x, y, t;
            logic neg_m, neg_n;
            a = longint'($signed(a_i));
            b = longint'($signed(b_i));
            c = longint'($signed(c_i));
            d = longint'($signed(d_i));
            r.error = 1'b0;
            r.negative = 1'b0;
            r.whole_part = '0;
            r.remainder_part = '0;
            r.denominator = 31'd1;
            if (b == 0 || d == 0 || (op_i == OP_DIV && c == 0)) begin
                r.error = 1'b1;
            end
            else begin
                case (op_i)
                    OP_ADD:
                    begin
                        m = a * d + b * c;
                        n = b * d;
                    end
                    OP_SUB:
                    begin
                        m = a * d - b * c;
                        n = b * d;
                    end
                    OP_MUL:
                    begin
                        m = a * c;
                        n = b * d;
                    end
                    default:
                    begin
                        m = a * d;
                        n = b * c;
                    end
                endcase
                if (m != 0) begin
                    neg_m = m < 0;
                    neg_n = n < 0;
                    um = neg_m ? longint'(-m) : m;
                    un = neg_n ? longint'(-n) : n;
                    x = um;
                    y = un;
                    while (y != 0) begin
                        t = x % y;
                        x = y;
                        y = t;
                    end
                    um = um / x;
                    un = un / x;
                    r.negative = neg_m ^ neg_n;
                    r.whole_part = 32'(um / un);
                    r.remainder_part = 30'(um % un);
                    r.denominator = 31'(un);
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(frac_result_t got);
            frac_result_t exp_r;
            if (pending.size() == 0) begin
                $error("result with no item outstanding");
                failures++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.error !== exp_r.error) begin
                $error("error: expected %0d actual %0d", exp_r.error, got.error);
                failures++;
            end
            if (got.negative !== exp_r.negative) begin
                $error("negative: expected %0d actual %0d", exp_r.negative, got.negative);
                failures++;
            end
            if (got.whole_part !== exp_r.whole_part) begin
                $error("whole_part: expected %0d actual %0d", exp_r.whole_part,
                       got.whole_part);
                failures++;
            end
            if (got.remainder_part !== exp_r.remainder_part) begin
                $error("remainder_part: expected %0d actual %0d", exp_r.remainder_part,
                       got.remainder_part);
                failures++;
            end
            if (got.denominator !== exp_r.denominator) begin
                $error("denominator: expected %0d actual %0d", exp_r.denominator,
                       got.denominator);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = OP_ADD;
    logic [15:0] num_a = '0;
    logic [15:0] den_b = '0;
    logic [15:0] num_c = '0;
    logic [15:0] den_d = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        error;
    logic        negative;
    logic [31:0] whole_part;
    logic [29:0] remainder_part;
    logic [30:0] denominator;

    frac_scoreboard sb = new();
    bit             quiet_stretch = 1'b0;

    fraction_arith_reduce u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .num_a(num_a),
        .den_b(den_b),
        .num_c(num_c),
        .den_d(den_d),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .error(error),
        .negative(negative),
        .whole_part(whole_part),
        .remainder_part(remainder_part),
        .denominator(denominator)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'(12'($urandom_range(0, 40)) - 12'd20);
            5: return 16'($urandom_range(1, 12) * $urandom_range(1, 12));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [1:0] o, logic [15:0] a, logic [15:0] b,
                             logic [15:0] c, logic [15:0] d);
        while (!quiet_stretch && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        op <= o;
        num_a <= a;
        den_b <= b;
        num_c <= c;
        den_d <= d;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(o, a, b, c, d);
    endtask

    always @(posedge clk) begin
        frac_result_t got;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got.error = error;
                got.negative = negative;
                got.whole_part = whole_part;
                got.remainder_part = remainder_part;
                got.denominator = denominator;
                sb.check_result(got);
            end
            out_ready <= quiet_stretch || ($urandom_range(0, 99) >= 15);
        end
    end

    initial begin
        logic [15:0] edges[6];
        edges = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h0003};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int o = 0; o < 4; o++) begin
            send_item(2'(o), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            send_item(2'(o), 16'h7fff, 16'h0001, 16'h8000, 16'hffff);
            send_item(2'(o), 16'h0001, 16'h0000, 16'h0001, 16'h0001);
            send_item(2'(o), 16'h0000, 16'h0003, 16'h0000, 16'h0005);
            send_item(2'(o), 16'hffff, 16'h0003, 16'h0001, 16'h0003);
        end
        send_item(OP_SUB, 16'h0001, 16'h0002, 16'h0001, 16'h0002);
        send_item(OP_ADD, 16'hffff, 16'h0004, 16'h0000, 16'h0001);
        for (int i = 0; i < 1530; i++) begin
            quiet_stretch = (i >= 600 && i < 800);
            if (i == 900) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 9) == 0)
                send_item(2'($urandom), edges[$urandom_range(0, 5)],
                          edges[$urandom_range(0, 5)], edges[$urandom_range(0, 5)],
                          edges[$urandom_range(0, 5)]);
            else
                send_item(2'($urandom), pick_operand(), pick_operand(), pick_operand(),
                          pick_operand());
        end
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.failures == 0)
            $display("fraction_arith_reduce test passed");
        else
            $display("fraction_arith_reduce test failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("fraction_arith_reduce test failed");
        $finish;
    end
endmodule

[files.f]
hw/rtl/far_pkg.sv
hw/rtl/far_divider.sv
hw/rtl/fraction_arith_reduce.sv
bench/tb_fraction_arith_reduce.sv
